// ----- hdl/rckt_pkg.sv -----
package rckt_pkg;

  // Field widths of the stream payloads.
  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 16;
  localparam int STATUS_W     = 3;
  localparam int OCC_W        = 10;
  localparam int ENTRY_W      = KEY_W + COUNT_W;
  localparam int OUT_FIELDS_W = STATUS_W + COUNT_W + OCC_W;
  localparam int OUT_TDATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation carried in in_tuser.
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INCR     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DECR     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic update;
    logic swap_wr;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic need_swap;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/rckt_ram.sv -----
module rckt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/rckt_ctrl.sv -----
module rckt_ctrl import rckt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_UPDATE  = 6'b000100,
    S_SWAP_WR = 6'b001000,
    S_RESP    = 6'b010000,
    S_SPARE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.need_swap ? S_SWAP_WR : S_RESP;
      end
      S_SWAP_WR: begin
        cmd.swap_wr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/rckt_dp.sv -----
module rckt_dp import rckt_pkg::*; #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [KEY_W-1:0]       in_tdata,
  input  logic                   in_tuser,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int OW = (CW > OCC_W) ? CW : OCC_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic signed [KEY_W-1:0]  key_r;
  logic                     kind_r;
  logic [CW-1:0]            rd_idx_r;
  logic [AW-1:0]            chk_idx_r;
  logic                     chk_vld_r;
  logic                     hit_r;
  logic [AW-1:0]            hit_idx_r;
  logic [COUNT_W-1:0]       hit_cnt_r;
  logic [CW-1:0]            used_r, used_nxt;
  logic [STATUS_W-1:0]      res_status_r, upd_status;
  logic [COUNT_W-1:0]       res_cnt_r, upd_cnt;
  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic [KEY_W-1:0]         rd_key;
  logic [COUNT_W-1:0]       rd_cnt;

  logic                     key_bad, match, scan_end;
  logic [CW-1:0]            last_idx;
  logic                     hit_is_last, remove_zero;
  logic                     upd_we;
  logic [AW-1:0]            upd_waddr;
  logic [ENTRY_W-1:0]       upd_wdata;
  logic [COUNT_W-1:0]       inc_cnt;
  logic [OW-1:0]            occ_ext;

  // Entry storage: count in the upper bits, key in the lower bits.
  rckt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = ram_rdata[KEY_W-1:0];
  assign rd_cnt = ram_rdata[ENTRY_W-1:KEY_W];

  // Scan status: an ignored key, a match on the entry read last cycle, or all entries checked.
  assign key_bad     = (key_r == '0) || key_r[KEY_W-1];
  assign match       = chk_vld_r && (rd_key == key_r);
  assign scan_end    = !chk_vld_r && (rd_idx_r >= used_r);
  assign last_idx    = used_r - CW'(1);
  assign hit_is_last = (CW'(hit_idx_r) == last_idx);
  assign remove_zero = (hit_cnt_r <= COUNT_W'(1));
  assign inc_cnt     = (hit_cnt_r == COUNT_MAX) ? COUNT_MAX : hit_cnt_r + COUNT_W'(1);

  assign sts.scan_done = key_bad || match || scan_end;
  assign sts.need_swap = !key_bad && (kind_r == KIND_REMOVE) && hit_r && remove_zero
                         && !hit_is_last;
  assign sts.out_free  = !out_tvalid_r || out_tready;

  // Outcome of the request once the scan has finished.
  always_comb begin
    upd_status = ST_IGNORED;
    upd_cnt    = '0;
    upd_we     = 1'b0;
    upd_waddr  = hit_idx_r;
    upd_wdata  = {inc_cnt, key_r};
    used_nxt   = used_r;
    if (key_bad) begin
      upd_status = ST_IGNORED;
    end else if (kind_r == KIND_ADD) begin
      if (hit_r) begin
        upd_status = ST_INCR;
        upd_cnt    = inc_cnt;
        upd_we     = 1'b1;
      end else if (used_r < DEPTH_C) begin
        upd_status = ST_INSERTED;
        upd_cnt    = COUNT_W'(1);
        upd_we     = 1'b1;
        upd_waddr  = used_r[AW-1:0];
        upd_wdata  = {COUNT_W'(1), key_r};
        used_nxt   = used_r + CW'(1);
      end else begin
        upd_status = ST_FULL;
      end
    end else begin
      if (!hit_r) begin
        upd_status = ST_NOTFOUND;
      end else if (remove_zero) begin
        upd_status = ST_REMOVED;
        used_nxt   = last_idx;
      end else begin
        upd_status = ST_DECR;
        upd_cnt    = hit_cnt_r - COUNT_W'(1);
        upd_we     = 1'b1;
        upd_wdata  = {hit_cnt_r - COUNT_W'(1), key_r};
      end
    end
  end

  // Memory port selection: scan reads, last-entry read, update and swap writes.
  always_comb begin
    ram_raddr = cmd.update ? last_idx[AW-1:0] : rd_idx_r[AW-1:0];
    ram_we    = (cmd.update && upd_we) || cmd.swap_wr;
    ram_waddr = cmd.swap_wr ? hit_idx_r : upd_waddr;
    ram_wdata = cmd.swap_wr ? ram_rdata : upd_wdata;
  end

  // Request capture and scan pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else if (cmd.capture) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else if (cmd.scan) begin
      if (rd_idx_r < used_r) begin
        rd_idx_r  <= rd_idx_r + CW'(1);
        chk_vld_r <= 1'b1;
      end else begin
        chk_vld_r <= 1'b0;
      end
      if (match) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Payload registers of the request being worked on.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r  <= in_tdata;
      kind_r <= in_tuser;
    end
    if (cmd.scan) begin
      chk_idx_r <= rd_idx_r[AW-1:0];
      if (match) begin
        hit_idx_r <= chk_idx_r;
        hit_cnt_r <= rd_cnt;
      end
    end
    if (cmd.update) begin
      res_status_r <= upd_status;
      res_cnt_r    <= upd_cnt;
    end
  end

  // Occupancy counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.update) begin
      used_r <= used_nxt;
    end
  end

  // Output register: holds one result while the receiver stalls.
  assign occ_ext = OW'(used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), occ_ext[OCC_W-1:0], res_cnt_r,
                     res_status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hdl/refcounted_key_table_top.sv -----
// Reference-counted key table.
// The input stream carries one request per beat: in_tuser selects add (0) or
// remove (1), in_tdata holds the signed 32-bit key. Keys of zero or below are
// ignored. The output stream returns one result per request in out_tdata:
// status, the key's count after the request, and the table occupancy.
// A request scans the occupied entries one per cycle through the entry RAM
// port, stopping at the first match; one that finds no match reads every
// occupied entry, an ignored key ends its scan at once, and a removal that
// moves the last entry into the freed slot adds a swap write step before
// the response. The next request is accepted in the cycle the result can
// first be taken, so with a full table of 512 entries a request can occupy
// the block for a scan of all 512, paced by the single read port of the
// entry RAM.
// One request is worked on at a time; in_tready is high only between
// requests. A finished result waits in the output register, so the next
// request is accepted while the receiver stalls; the block then holds at its
// response step until the output register frees up.
// Reset empties the table at once; the RAM contents need no clearing since
// only entries below the occupancy are ever used.
module refcounted_key_table_top import rckt_pkg::*; #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_W-1:0]       in_tdata,   // [31:0] key
  input  logic                   in_tuser,   // [0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [2:0] status, [18:3] count_after,
                                             // [28:19] occupancy, [31:29] zero
);

  cmd_t cmd;
  sts_t sts;

  rckt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rckt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- sim/key_table_checker.sv -----
`timescale 1ns / 100ps

// Watches both streams of the key table, keeps a shadow copy of the table,
// predicts the result of every accepted request and compares each returned
// result against the oldest prediction.
module key_table_checker import rckt_pkg::*; #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [KEY_W-1:0]       in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatch_count,
  output int                     results_owed,
  output int                     table_fill
);

  // Result fields, status in the lowest bits as on out_tdata.
  typedef struct packed {
    logic [OCC_W-1:0]    occ;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } table_result_t;

  logic [KEY_W-1:0]   shadow_keys   [TABLE_DEPTH];
  logic [COUNT_W-1:0] shadow_counts [TABLE_DEPTH];
  int                 shadow_used;

  table_result_t pending_results[$];
  int            result_index;

  // Applies one request to the shadow table and returns the result it causes.
  function automatic table_result_t predict_table_result(logic kind, logic [KEY_W-1:0] key);
    table_result_t res;
    int            slot;
    int            last;
    res        = '0;
    res.status = ST_IGNORED;
    slot       = shadow_used;
    for (int i = shadow_used - 1; i >= 0; i--) begin
      if (shadow_keys[i] == key) begin
        slot = i;
      end
    end
    if (key == '0 || key[KEY_W-1]) begin
      res.status = ST_IGNORED;
    end else if (kind == KIND_ADD) begin
      if (slot < shadow_used) begin
        // The count saturates but the request still reports an increment.
        if (shadow_counts[slot] != COUNT_MAX) begin
          shadow_counts[slot] = shadow_counts[slot] + 1'b1;
        end
        res.count  = shadow_counts[slot];
        res.status = ST_INCR;
      end else if (shadow_used < TABLE_DEPTH) begin
        shadow_keys[shadow_used]   = key;
        shadow_counts[shadow_used] = COUNT_W'(1);
        shadow_used++;
        res.count  = COUNT_W'(1);
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (slot < shadow_used) begin
        if (shadow_counts[slot] > 1) begin
          shadow_counts[slot] = shadow_counts[slot] - 1'b1;
          res.count  = shadow_counts[slot];
          res.status = ST_DECR;
        end else begin
          // The last entry moves into the freed slot.
          last = shadow_used - 1;
          if (slot < last) begin
            shadow_keys[slot]   = shadow_keys[last];
            shadow_counts[slot] = shadow_counts[last];
          end
          shadow_used = last;
          res.status  = ST_REMOVED;
        end
      end else begin
        res.status = ST_NOTFOUND;
      end
    end
    res.occ = shadow_used[OCC_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    $display("result %0d: %s expected %0d, got %0d", result_index, field, want, got);
    mismatch_count++;
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = table_result_t'(out_tdata[OUT_FIELDS_W-1:0]);
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, tdata", 0, out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status) begin
            report_mismatch("status", 32'(want.status), 32'(got.status));
          end
          if (got.count != want.count) begin
            report_mismatch("count_after", 32'(want.count), 32'(got.count));
          end
          if (got.occ != want.occ) begin
            report_mismatch("occupancy", 32'(want.occ), 32'(got.occ));
          end
          if (out_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] != '0) begin
            report_mismatch("padding", 0, 32'(out_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]));
          end
        end
        result_index++;
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(predict_table_result(in_tuser, in_tdata));
      end
      results_owed <= pending_results.size();
      table_fill   <= shadow_used;
    end
  end

endmodule

// ----- sim/refcounted_key_table_top_tb.sv -----
`timescale 1ns / 100ps

module refcounted_key_table_top_tb;
  import rckt_pkg::*;

  localparam int TABLE_DEPTH   = 512;
  localparam int RANDOM_ITEMS  = 1160;
  localparam int LONG_HOLD     = 3000;
  // The limit covers the slowest correct run: every request at a full
  // scan plus the longest gap and stall on both sides, and the long hold.
  localparam int CYCLE_LIMIT   = 4_000_000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [KEY_W-1:0]       in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatch_count;
  int results_owed;
  int table_fill;

  int tx_gap_max = 19;
  int rx_gap_max = 19;
  bit hold_req;
  int cycle_count;

  logic [KEY_W-1:0] key_pool[$];

  refcounted_key_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  key_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed),
    .table_fill    (table_fill)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result receiver: a random stall before each result, once a long hold.
  initial begin
    int stall;
    forever begin
      stall = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(logic kind, logic [KEY_W-1:0] key);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= key;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
  endtask

  // Stops offering until every predicted result has come back.
  task automatic wait_results_home();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    k[KEY_W-1] = 1'b0;
    if (k == '0) begin
      k = 1;
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] ignored_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    k[KEY_W-1] = 1'b1;
    return ($urandom_range(0, 3) == 0) ? '0 : k;
  endfunction

  // One random request; fresh_pct sets the share of new keys being added.
  task automatic random_request(int fresh_pct);
    int               dice;
    int               pick;
    logic [KEY_W-1:0] k;
    dice = $urandom_range(0, 99);
    pick = (dice - fresh_pct) * 100 / (100 - fresh_pct);
    if (dice < fresh_pct || key_pool.size() == 0) begin
      k = fresh_key();
      key_pool.push_back(k);
      send_request(KIND_ADD, k);
    end else if (pick < 35) begin
      send_request(KIND_ADD, key_pool[$urandom_range(0, key_pool.size() - 1)]);
    end else if (pick < 80) begin
      send_request(KIND_REMOVE, key_pool[$urandom_range(0, key_pool.size() - 1)]);
    end else if (pick < 90) begin
      // Most likely a key that was never stored.
      send_request(KIND_REMOVE, fresh_key());
    end else begin
      send_request(1'($urandom_range(0, 1)), ignored_key());
    end
  endtask

  // Some stretches run without any idling on either side.
  task automatic draw_idling();
    tx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 19;
    rx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 19;
  endtask

  initial begin
    int items;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on an empty table.
    send_request(KIND_REMOVE, 32'd5);            // remove from an empty table
    send_request(KIND_ADD,    32'h0000_0000);    // zero key is ignored
    send_request(KIND_ADD,    32'h8000_0000);    // most negative key is ignored
    send_request(KIND_REMOVE, 32'hFFFF_FFFF);    // minus one is ignored
    send_request(KIND_REMOVE, 32'h0000_0000);
    send_request(KIND_ADD,    32'd1);            // smallest valid key
    send_request(KIND_ADD,    32'h7FFF_FFFF);    // largest valid key
    send_request(KIND_ADD,    32'd1);            // count goes to two
    send_request(KIND_ADD,    32'h1234_5678);
    send_request(KIND_REMOVE, 32'd1);            // plain decrement
    send_request(KIND_REMOVE, 32'd1);            // removal from the first slot, last moves
    send_request(KIND_REMOVE, 32'h1234_5678);    // removal from the first slot again
    send_request(KIND_REMOVE, 32'h7FFF_FFFF);    // removal of the last entry itself
    send_request(KIND_REMOVE, 32'h7FFF_FFFF);    // now absent
    send_request(KIND_ADD,    32'h2AAA_AAAA);
    send_request(KIND_ADD,    32'h5555_5555);
    send_request(KIND_REMOVE, 32'h5555_5555);
    send_request(KIND_REMOVE, 32'h2AAA_AAAA);
    wait_results_home();

    // Fill the table mostly with new keys, then keep sending requests, half of them new keys being added.
    items = 0;
    while (table_fill < TABLE_DEPTH && items < 900) begin
      if (items % 64 == 0) begin
        draw_idling();
      end
      random_request(88);
      items++;
    end
    repeat (30) begin
      random_request(50);
      items++;
    end

    // Churn: the sender waits for all results, then a long receiver hold
    // fills the block while requests keep coming.
    wait_results_home();
    tx_gap_max = 0;
    rx_gap_max = 19;
    hold_req   = 1'b1;
    while (items < RANDOM_ITEMS) begin
      if (items % 64 == 0) begin
        draw_idling();
      end
      random_request(15);
      items++;
    end

    wait_results_home();
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rckt_pkg.sv
hdl/rckt_ram.sv
hdl/rckt_ctrl.sv
hdl/rckt_dp.sv
hdl/refcounted_key_table_top.sv
sim/key_table_checker.sv
sim/refcounted_key_table_top_tb.sv
